// File: sv/encoder_frame_crc6_checker_top_defines.svh
`ifndef ENCODER_FRAME_CRC6_CHECKER_TOP_DEFINES_SVH
`define ENCODER_FRAME_CRC6_CHECKER_TOP_DEFINES_SVH

// a signal must hold while its word is offered but not taken
`define EFCRC6_ASSERT_HOLD(label, vld, rdy, sig) \
   label: assert property (@(posedge clock) disable iff (reset) \
      ((vld) && !(rdy)) |=> $stable(sig)) else $error("stalled word changed");

// plain implication, checked out of reset
`define EFCRC6_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (ante) |-> (cons)) else $error("implication failed");

`endif

// File: sv/efcrc6_pkg.sv
`timescale 1ns / 1ps

package efcrc6_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned FRAME_W   = 24;
   localparam int unsigned PART_W    = 16;
   localparam int unsigned PAYLOAD_W = 18;
   localparam int unsigned ANGLE_W   = 14;
   localparam int unsigned STATUS_W  = 4;
   localparam int unsigned CRC_W     = 6;

   localparam logic OUTCOME_OK      = 1'b0;
   localparam logic OUTCOME_CRC_ERR = 1'b1;

   // bytes of the current frame already held
   typedef enum logic [1:0] {
      CNT_NONE = 2'd0,
      CNT_ONE  = 2'd1,
      CNT_TWO  = 2'd2
   } byte_count_type;

   typedef struct packed {
      logic               vld;
      logic [FRAME_W-1:0] bits;
   } frame_stage_type;

   // x^(i+6) mod x^6+x+1: contribution of payload bit i to the crc
   localparam logic [CRC_W-1:0] CRC_COLUMN [PAYLOAD_W] = '{
      6'h03, 6'h06, 6'h0C, 6'h18, 6'h30, 6'h23, 6'h05, 6'h0A, 6'h14,
      6'h28, 6'h13, 6'h26, 6'h0F, 6'h1E, 6'h3C, 6'h3B, 6'h35, 6'h29
   };

   function automatic logic [CRC_W-1:0] crc6_of18(input logic [PAYLOAD_W-1:0] payload);
      logic [CRC_W-1:0] crc;
      crc = '0;
      for (int i = 0; i < PAYLOAD_W; i++) begin
         if (payload[i]) begin
            crc = crc ^ CRC_COLUMN[i];
         end
      end
      return crc;
   endfunction

endpackage

// File: sv/efcrc6_if.sv
`timescale 1ns / 1ps

interface efcrc6_req_if
   import efcrc6_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface efcrc6_rsp_if
   import efcrc6_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [ANGLE_W-1:0]  angle;
   logic [STATUS_W-1:0] status_bits;
   logic [CRC_W-1:0]    crc_carried;
   logic [CRC_W-1:0]    crc_computed;
   logic                outcome;

   modport source (output valid, output angle, output status_bits, output crc_carried,
                   output crc_computed, output outcome, input ready);
   modport sink (input valid, input angle, input status_bits, input crc_carried,
                 input crc_computed, input outcome, output ready);
endinterface

// File: sv/efcrc6_assemble.sv
`timescale 1ns / 1ps

module efcrc6_assemble
   import efcrc6_pkg::*;
   (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic            frame_start,
   output frame_stage_type frm,
   input  logic            frm_ready
);

   byte_count_type     count_ff, count_in, count_now;
   logic [PART_W-1:0]  partial_ff, partial_in;
   frame_stage_type    frm_ff, frm_in;
   logic               accept;

   assign in_ready = !frm_ff.vld || frm_ready;
   assign accept   = in_valid && in_ready;
   assign frm      = frm_ff;

   always_comb begin
      count_now  = frame_start ? CNT_NONE : count_ff;
      count_in   = count_ff;
      partial_in = partial_ff;
      frm_in     = frm_ff;
      if (frm_ready) begin
         frm_in.vld = 1'b0;
      end
      if (accept) begin
         unique case (count_now)
            CNT_ONE: begin
               partial_in = {partial_ff[BYTE_W-1:0], rx_byte};
               count_in   = CNT_TWO;
            end
            CNT_TWO: begin
               frm_in.vld  = 1'b1;
               frm_in.bits = {partial_ff, rx_byte};
               partial_in  = '0;
               count_in    = CNT_NONE;
            end
            default: begin
               // start of a frame, also the unused count code
               partial_in = {{(PART_W-BYTE_W){1'b0}}, rx_byte};
               count_in   = CNT_ONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= CNT_NONE;
         partial_ff <= '0;
         frm_ff.vld <= 1'b0;
      end else begin
         count_ff   <= count_in;
         partial_ff <= partial_in;
         frm_ff.vld <= frm_in.vld;
      end
      frm_ff.bits <= frm_in.bits;
   end

endmodule

// File: sv/efcrc6_check.sv
`timescale 1ns / 1ps

module efcrc6_check
   import efcrc6_pkg::*;
   (
   input  logic                clock,
   input  logic                reset,
   input  frame_stage_type     frm,
   output logic                frm_ready,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [ANGLE_W-1:0]  angle,
   output logic [STATUS_W-1:0] status_bits,
   output logic [CRC_W-1:0]    crc_carried,
   output logic [CRC_W-1:0]    crc_computed,
   output logic                outcome
);

   logic                vld_ff, vld_in;
   logic [ANGLE_W-1:0]  angle_ff, angle_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [CRC_W-1:0]    crc_rx_ff, crc_rx_in;
   logic [CRC_W-1:0]    crc_calc_ff, crc_calc_in;
   logic                outcome_ff, outcome_in;
   logic                take;

   assign frm_ready = !vld_ff || out_ready;
   assign take      = frm.vld && frm_ready;

   always_comb begin
      angle_in    = frm.bits[FRAME_W-1 -: ANGLE_W];
      status_in   = frm.bits[CRC_W +: STATUS_W];
      crc_rx_in   = frm.bits[CRC_W-1:0];
      crc_calc_in = crc6_of18(frm.bits[FRAME_W-1:CRC_W]);
      outcome_in  = (crc_rx_in != crc_calc_in) ? OUTCOME_CRC_ERR : OUTCOME_OK;
      vld_in      = take ? 1'b1 : (out_ready ? 1'b0 : vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (take) begin
         angle_ff    <= angle_in;
         status_ff   <= status_in;
         crc_rx_ff   <= crc_rx_in;
         crc_calc_ff <= crc_calc_in;
         outcome_ff  <= outcome_in;
      end
   end

   assign out_valid    = vld_ff;
   assign angle        = angle_ff;
   assign status_bits  = status_ff;
   assign crc_carried  = crc_rx_ff;
   assign crc_computed = crc_calc_ff;
   assign outcome      = outcome_ff;

endmodule

// File: sv/encoder_frame_crc6_checker_top.sv
`timescale 1ns / 1ps

// Encoder frame CRC-6 checker.
// req_ch carries one frame byte per word, most significant byte first, with
// frame_start marking the first byte of a frame; without it the count runs
// freely and every third byte closes a frame.
// rsp_ch carries one word per completed frame: angle, status bits, the
// received crc, the crc computed over the upper 18 frame bits and the
// outcome (ok or crc mismatch). Bytes one and two produce no word.
// Path: the third byte closes the frame into the frame register; the check
// then loads the result register, from which the result word is offered.
// req_ch takes one byte per cycle while req_ch.ready is high; the crc is a
// combinational xor network.
// A stalled result holds in the result register while the frame register
// still takes one more frame; req_ch.ready drops only when both are full.
// Synchronous reset empties both registers and restarts the byte count.

module encoder_frame_crc6_checker_top
   import efcrc6_pkg::*;
   (
   input  logic          clock,
   input  logic          reset,
   efcrc6_req_if.sink    req_ch,
   efcrc6_rsp_if.source  rsp_ch
);

   frame_stage_type frm;
   logic            frm_ready;

   efcrc6_assemble u_assemble (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_ch.valid),
      .in_ready    (req_ch.ready),
      .rx_byte     (req_ch.rx_byte),
      .frame_start (req_ch.frame_start),
      .frm         (frm),
      .frm_ready   (frm_ready)
   );

   efcrc6_check u_check (
      .clock        (clock),
      .reset        (reset),
      .frm          (frm),
      .frm_ready    (frm_ready),
      .out_valid    (rsp_ch.valid),
      .out_ready    (rsp_ch.ready),
      .angle        (rsp_ch.angle),
      .status_bits  (rsp_ch.status_bits),
      .crc_carried  (rsp_ch.crc_carried),
      .crc_computed (rsp_ch.crc_computed),
      .outcome      (rsp_ch.outcome)
   );

endmodule

// File: sv/efcrc6_sva.sv
`timescale 1ns / 1ps
`include "encoder_frame_crc6_checker_top_defines.svh"

module efcrc6_sva (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [13:0] rsp_angle,
   input logic [3:0]  rsp_status_bits,
   input logic [5:0]  rsp_crc_carried,
   input logic [5:0]  rsp_crc_computed,
   input logic        rsp_outcome
);

   logic [30:0] rsp_word;
   logic        req_take;

   assign rsp_word = {rsp_angle, rsp_status_bits, rsp_crc_carried, rsp_crc_computed,
                      rsp_outcome};
   assign req_take = req_valid && req_ready;

   `EFCRC6_ASSERT_HOLD(a_rsp_hold, rsp_valid, rsp_ready, rsp_word)
   `EFCRC6_ASSERT_IMPL(a_outcome_match, rsp_valid, rsp_outcome == (rsp_crc_carried != rsp_crc_computed))
   // a fresh result follows the taken byte that closed its frame, through the frame and result registers
   `EFCRC6_ASSERT_IMPL(a_rsp_latency, $rose(rsp_valid), $past(req_take, 2))

endmodule

bind encoder_frame_crc6_checker_top efcrc6_sva u_efcrc6_sva (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_angle        (rsp_ch.angle),
   .rsp_status_bits  (rsp_ch.status_bits),
   .rsp_crc_carried  (rsp_ch.crc_carried),
   .rsp_crc_computed (rsp_ch.crc_computed),
   .rsp_outcome      (rsp_ch.outcome)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import efcrc6_pkg::*;

   localparam logic [CRC_W-1:0] CRC_TAPS = 6'h03;
   localparam int unsigned PLAN_LEN = 25;
   localparam int unsigned RANDOM_BYTES = 1200;

   typedef struct packed {
      logic [ANGLE_W-1:0]  angle;
      logic [STATUS_W-1:0] status_bits;
      logic [CRC_W-1:0]    crc_carried;
      logic [CRC_W-1:0]    crc_computed;
      logic                outcome;
   } frame_word_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              start;
      logic              pinned;
      frame_word_type    want;
   } stim_row_type;

   localparam frame_word_type NO_WORD = '0;

   logic clock;
   logic reset;

   efcrc6_req_if req_ch ();
   efcrc6_rsp_if rsp_ch ();

   encoder_frame_crc6_checker_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // frame tracking state of the predictor
   byte_count_type     fill;
   logic [PART_W-1:0]  held;

   frame_word_type frames_due [$];
   frame_word_type seen_word;
   frame_word_type due_word;
   frame_word_type next_word;
   frame_word_type pin_word;
   bit             pin_active;
   bit             calm;

   int unsigned errors;
   int unsigned bytes_sent;
   int unsigned frames_checked;
   int unsigned frames_ok;
   int unsigned frames_bad;
   int unsigned restarts;

   // directed words; pinned rows carry a hand-written result
   stim_row_type plan [PLAN_LEN] = '{
      '{8'h00, 1'b1, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b1, '{14'h0000, 4'h0, 6'h00, 6'h00, OUTCOME_OK}},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h01, 1'b0, 1'b1, '{14'h0000, 4'h0, 6'h01, 6'h00, OUTCOME_CRC_ERR}},
      '{8'hFF, 1'b1, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, 1'b0, NO_WORD},
      '{8'hFF, 1'b0, 1'b0, NO_WORD},
      '{8'hAA, 1'b1, 1'b0, NO_WORD},
      '{8'h55, 1'b1, 1'b0, NO_WORD},
      '{8'h12, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b1, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h43, 1'b0, 1'b1, '{14'h0000, 4'h1, 6'h03, 6'h03, OUTCOME_OK}},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h86, 1'b0, 1'b1, '{14'h0000, 4'h2, 6'h06, 6'h06, OUTCOME_OK}},
      '{8'h00, 1'b1, 1'b0, NO_WORD},
      '{8'h00, 1'b1, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h3F, 1'b0, 1'b1, '{14'h0000, 4'h0, 6'h3F, 6'h00, OUTCOME_CRC_ERR}},
      '{8'h80, 1'b1, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD},
      '{8'h00, 1'b0, 1'b0, NO_WORD}
   };

   // bit-serial crc-6, x^6+x+1, msb first, zero start
   function automatic logic [CRC_W-1:0] crc6_serial(input logic [PAYLOAD_W-1:0] payload);
      logic [CRC_W-1:0] r;
      logic             fb;
      r = '0;
      for (int k = PAYLOAD_W - 1; k >= 0; k--) begin
         fb = r[CRC_W-1] ^ payload[k];
         r  = {r[CRC_W-2:0], 1'b0};
         if (fb) begin
            r = r ^ CRC_TAPS;
         end
      end
      return r;
   endfunction

   // advances the frame tracker by one byte; returns 1 when a frame closes
   function automatic bit frame_step(input logic [BYTE_W-1:0] b, input logic s,
                                     output frame_word_type w);
      byte_count_type     at;
      logic [FRAME_W-1:0] frame;
      at = s ? CNT_NONE : fill;
      w  = NO_WORD;
      case (at)
         CNT_ONE: begin
            held = {held[BYTE_W-1:0], b};
            fill = CNT_TWO;
            return 1'b0;
         end
         CNT_TWO: begin
            frame = {held, b};
            fill  = CNT_NONE;
            held  = '0;
            w.angle        = frame[FRAME_W-1 -: ANGLE_W];
            w.status_bits  = frame[CRC_W +: STATUS_W];
            w.crc_carried  = frame[CRC_W-1:0];
            w.crc_computed = crc6_serial(frame[FRAME_W-1 -: PAYLOAD_W]);
            w.outcome      = (w.crc_carried == w.crc_computed) ? OUTCOME_OK
                                                               : OUTCOME_CRC_ERR;
            return 1'b1;
         end
         default: begin
            held = {{(PART_W-BYTE_W){1'b0}}, b};
            fill = CNT_ONE;
            return 1'b0;
         end
      endcase
   endfunction

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      $display("mismatch in %s at frame %0d: got 0x%0h, want 0x%0h",
               what, frames_checked, got, want);
      errors++;
   endtask

   // offers one byte; a frame head is forced to carry the start flag mid-frame
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic s, input bit head,
                            input bit pinned, input frame_word_type want);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 31) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      if (head && fill != CNT_NONE) begin
         s = 1'b1;
      end
      pin_active = pinned;
      pin_word   = want;
      req_ch.valid       <= 1'b1;
      req_ch.rx_byte     <= b;
      req_ch.frame_start <= s;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // result side back-pressure
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 31);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen_word.angle        = rsp_ch.angle;
            seen_word.status_bits  = rsp_ch.status_bits;
            seen_word.crc_carried  = rsp_ch.crc_carried;
            seen_word.crc_computed = rsp_ch.crc_computed;
            seen_word.outcome      = rsp_ch.outcome;
            if (seen_word.outcome == OUTCOME_OK) begin
               frames_ok++;
            end else begin
               frames_bad++;
            end
            if (frames_due.size() == 0) begin
               flag_mismatch("unrequested result word", 32'(seen_word.angle), 0);
            end else begin
               due_word = frames_due.pop_front();
               if (seen_word.angle != due_word.angle)
                  flag_mismatch("angle", 32'(seen_word.angle), 32'(due_word.angle));
               if (seen_word.status_bits != due_word.status_bits)
                  flag_mismatch("status_bits", 32'(seen_word.status_bits),
                                32'(due_word.status_bits));
               if (seen_word.crc_carried != due_word.crc_carried)
                  flag_mismatch("crc_carried", 32'(seen_word.crc_carried),
                                32'(due_word.crc_carried));
               if (seen_word.crc_computed != due_word.crc_computed)
                  flag_mismatch("crc_computed", 32'(seen_word.crc_computed),
                                32'(due_word.crc_computed));
               if (seen_word.outcome != due_word.outcome)
                  flag_mismatch("outcome", 32'(seen_word.outcome), 32'(due_word.outcome));
            end
            frames_checked++;
         end
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.frame_start && fill != CNT_NONE) begin
               restarts++;
            end
            if (frame_step(req_ch.rx_byte, req_ch.frame_start, next_word)) begin
               frames_due.push_back(pin_active ? pin_word : next_word);
            end else if (pin_active) begin
               flag_mismatch("directed row closing no frame", 0, 1);
            end
         end
      end
   end

   initial begin
      logic [PAYLOAD_W-1:0] payload;
      logic [CRC_W-1:0]     crc;
      logic [FRAME_W-1:0]   frame;
      int unsigned          r;
      int unsigned          n;
      int unsigned          guard;
      bit                   paused;

      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.rx_byte     = '0;
      req_ch.frame_start = 1'b0;
      fill               = CNT_NONE;
      held               = '0;
      pin_active         = 1'b0;
      pin_word           = NO_WORD;
      calm               = 1'b0;
      paused             = 1'b0;
      errors             = 0;
      bytes_sent         = 0;
      frames_checked     = 0;
      frames_ok          = 0;
      frames_bad         = 0;
      restarts           = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_LEN; i++) begin
         send_byte(plan[i].data, plan[i].start, 1'b0, plan[i].pinned, plan[i].want);
      end

      while (bytes_sent < PLAN_LEN + RANDOM_BYTES) begin
         calm = (bytes_sent >= 300) && (bytes_sent < 520);
         if (!paused && bytes_sent >= 700) begin
            // hold off until every frame result has drained
            @(negedge clock);
            req_ch.valid <= 1'b0;
            while (frames_due.size() != 0) @(negedge clock);
            paused = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 78) begin
            payload = PAYLOAD_W'($urandom);
            n = $urandom_range(0, 19);
            if (n == 0) payload = '0;
            if (n == 1) payload = '1;
            crc = $urandom_range(0, 1) ? crc6_serial(payload) : CRC_W'($urandom);
            frame = {payload, crc};
            send_byte(frame[23:16], 1'($urandom_range(0, 1)), 1'b1, 1'b0, NO_WORD);
            send_byte(frame[15:8], 1'b0, 1'b0, 1'b0, NO_WORD);
            send_byte(frame[7:0], 1'b0, 1'b0, 1'b0, NO_WORD);
         end else if (r < 90) begin
            // truncated frame, cut short by the next start flag unless loose bytes complete it
            n = $urandom_range(1, 2);
            for (int j = 0; j < n; j++) begin
               send_byte(BYTE_W'($urandom), (j == 0), 1'b0, 1'b0, NO_WORD);
            end
         end else begin
            send_byte(BYTE_W'($urandom), 1'($urandom_range(0, 1)), 1'b0, 1'b0, NO_WORD);
         end
      end
      calm = 1'b0;

      @(negedge clock);
      req_ch.valid <= 1'b0;
      guard = 0;
      while (frames_due.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
      if (frames_due.size() != 0) begin
         flag_mismatch("frame results never delivered", 32'(frames_due.size()), 0);
      end

      $display("sent %0d frame bytes; checked %0d result words (%0d crc ok, %0d crc bad)",
               bytes_sent, frames_checked, frames_ok, frames_bad);
      $display("framing covered %0d mid-frame restarts, free-running frames, one drain pause",
               restarts);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
